// ===== rtl/core/sha256_pkg.sv =====
// Shared types, constants and functions of the SHA-256 byte stream hasher.
// Holds the round constants, the initial hash values and the sigma functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] hash_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       step;
  } sched_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctl_t;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned ROUND_W     = $clog2(ROUNDS);
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [63:0] BYTE_BITS   = 64'd8;

  localparam hash_t IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_sched.sv =====
// Block buffer and message schedule: a 16-word window that takes bytes
// during fill and rolls one schedule word per round. Uses sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_sched (
  input  wire                          clk,
  input  wire sha256_pkg::sched_ctl_t  ctl,
  output sha256_pkg::word_t            w_cur
);

  logic [511:0]      wnd;
  sha256_pkg::word_t w_new;

  assign w_cur = wnd[511:480];
  assign w_new = sha256_pkg::ssig1(wnd[63:32]) + wnd[223:192]
               + sha256_pkg::ssig0(wnd[479:448]) + wnd[511:480];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      wnd <= {wnd[503:0], ctl.push_byte};
    end else if (ctl.step) begin
      wnd <= {wnd[479:0], w_new};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_round.sv =====
// Working variables a..h and the shared compression round, one round a cycle.
// Uses sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_round (
  input  wire                          clk,
  input  wire sha256_pkg::round_ctl_t  ctl,
  input  wire sha256_pkg::hash_t       chain,
  input  wire sha256_pkg::word_t       k,
  input  wire sha256_pkg::word_t       w,
  output sha256_pkg::hash_t            work
);

  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t maj;

  assign ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1  = work[7] + sha256_pkg::bsig1(work[4]) + ch + k + w;
  assign t2  = sha256_pkg::bsig0(work[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= chain;
    end else if (ctl.step) begin
      work <= '{t1 + t2, work[0], work[1], work[2],
                work[3] + t1, work[4], work[5], work[6]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher_core.sv =====
// Top level of the SHA-256 byte stream hasher: sequencer, chaining words,
// bit count and digest output. Uses sha256_pkg, sha256_sched, sha256_round.
//
// Input channel (s_*): one message byte per item in s_tdata, s_tuser set when
// the byte is part of the message, s_tlast on the final item of a message.
// An item with s_tuser low and s_tlast high ends a message without a byte.
// Output channel (m_*): eight digest words per message, H0 first, with the
// word index beside each word and m_tlast on the eighth.
// A byte item is taken while s_tready is high. The 64th byte of a block starts
// compression: 64 rounds through the single round unit, then the chain add.
// Ending a message pushes pad and length bytes one per cycle up to the
// block end, then compresses; that is 9 to 72 pad and length bytes and one
// or two compressions, then eight digest words on the output channel.
// The round unit limits how fast bytes go in: no byte is taken during compression.
// s_tready is high only while the block waits for input; it stays low
// through compression and while digest words wait. A stalled receiver holds
// the current word on m_tdata. Reset loads the initial hash values, clears
// the fill count and bit count, and drops any item in progress.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte
  input  wire         s_tuser,   // has_byte
  input  wire         s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_tlast    // last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_COMP = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic [sha256_pkg::FILL_W-1:0]  FILL_LAST = '1;
  localparam logic [sha256_pkg::FILL_W-1:0]  FILL_PRE_LEN =
    sha256_pkg::FILL_W'(sha256_pkg::BLOCK_BYTES - 9);
  localparam logic [sha256_pkg::ROUND_W-1:0] ROUND_LAST = '1;
  localparam logic [2:0]                     WORD_LAST  = 3'd7;

  logic [2:0]                     state;
  logic [2:0]                     ret_state;
  logic [sha256_pkg::FILL_W-1:0]  fill;
  logic [sha256_pkg::ROUND_W-1:0] round;
  logic                           pad_first;
  logic [63:0]                    bit_len;
  logic [2:0]                     widx;
  sha256_pkg::hash_t              chain;
  sha256_pkg::hash_t              work;
  sha256_pkg::word_t              w_cur;
  sha256_pkg::sched_ctl_t         sched_ctl;
  sha256_pkg::round_ctl_t         round_ctl;
  logic                           in_acc;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'b00000, widx, chain[widx]};
  assign m_tlast  = (widx == WORD_LAST);

  always_comb begin
    sched_ctl.push      = 1'b0;
    sched_ctl.push_byte = 8'h00;
    unique case (state)
      ST_IDLE: begin
        sched_ctl.push      = in_acc & s_tuser;
        sched_ctl.push_byte = s_tdata;
      end
      ST_PAD: begin
        sched_ctl.push      = 1'b1;
        sched_ctl.push_byte = pad_first ? sha256_pkg::PAD_BYTE : 8'h00;
      end
      ST_LEN: begin
        sched_ctl.push      = 1'b1;
        sched_ctl.push_byte = bit_len[63:56];
      end
      default: begin
        sched_ctl.push      = 1'b0;
        sched_ctl.push_byte = 8'h00;
      end
    endcase
    sched_ctl.step = (state == ST_COMP);
    round_ctl.load = sched_ctl.push && (fill == FILL_LAST);
    round_ctl.step = (state == ST_COMP);
  end

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha256_round u_round (
    .clk   (clk),
    .ctl   (round_ctl),
    .chain (chain),
    .k     (sha256_pkg::K[round]),
    .w     (w_cur),
    .work  (work)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      fill      <= '0;
      round     <= '0;
      pad_first <= 1'b0;
      bit_len   <= '0;
      widx      <= '0;
      chain     <= sha256_pkg::IV;
    end else begin
      if (sched_ctl.push) begin
        fill <= fill + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tuser) begin
              bit_len <= bit_len + sha256_pkg::BYTE_BITS;
            end
            if (s_tlast) begin
              pad_first <= 1'b1;
            end
            if (s_tuser && fill == FILL_LAST) begin
              state     <= ST_COMP;
              round     <= '0;
              ret_state <= s_tlast ? ST_PAD : ST_IDLE;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (fill == FILL_LAST) begin
            state     <= ST_COMP;
            round     <= '0;
            ret_state <= ST_PAD;
          end else if (fill == FILL_PRE_LEN) begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          bit_len <= {bit_len[55:0], 8'h00};
          if (fill == FILL_LAST) begin
            state     <= ST_COMP;
            round     <= '0;
            ret_state <= ST_OUT;
          end
        end
        ST_COMP: begin
          round <= round + 1'b1;
          if (round == ROUND_LAST) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          widx  <= '0;
          state <= ret_state;
        end
        ST_OUT: begin
          if (m_tready) begin
            widx <= widx + 1'b1;
            if (widx == WORD_LAST) begin
              chain   <= sha256_pkg::IV;
              bit_len <= '0;
              state   <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
